>>> rtl/lr_pkg.sv
// Shared constants for the line rasteriser: coordinate width default and request codes.
package lr_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Request kinds carried on the slave-side tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

endpackage : lr_pkg

>>> rtl/line_rasterizer_top.sv
// Top level of the Bresenham line rasteriser: input register, set-up, step core, result register.
//
// The block takes one word per clock while s_tready is high and returns one word per accepted
// word. A load word (tuser = 0) sets up a line from two endpoints and answers with line_empty;
// each step word (tuser = 1) answers with the next pixel of the line, last_pixel marking the
// final one, or an all-zero word when no line is running. The end point itself is never emitted.
// A word passes through the input register and the result register, so its result is registered
// on the master side; one add and compare on the decision term per cycle sets the rate of one
// pixel per clock while m_tready stays high. s_tready falls only while both registers are full
// and m_tready is low.
module line_rasterizer_top import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int DEC_BITS  = COORD_BITS + 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end, zero pad
    input  logic             s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y, zero pad
    output logic [1:0]       m_tuser,   // pixel_valid, line_empty
    output logic             m_tlast    // last_pixel
);

    logic                         in_valid_reg;
    logic                         in_type_reg;
    logic signed [COORD_BITS-1:0] x_start_reg;
    logic signed [COORD_BITS-1:0] y_start_reg;
    logic signed [COORD_BITS-1:0] x_end_reg;
    logic signed [COORD_BITS-1:0] y_end_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         advance;
    logic                         accept;

    logic                         ld_y_major;
    logic signed [COORD_BITS-1:0] ld_major_start;
    logic signed [COORD_BITS-1:0] ld_major_stop;
    logic signed [COORD_BITS-1:0] ld_minor_start;
    logic                         ld_minor_dir_neg;
    logic        [COORD_BITS:0]   ld_delta_major;
    logic        [COORD_BITS:0]   ld_delta_minor;
    logic signed [DEC_BITS-1:0]   ld_decision;
    logic                         ld_busy;

    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;
    logic                         line_empty;

    // move the held word into the result register when that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_type_reg <= s_tuser;
            x_start_reg <= s_tdata[COORD_BITS-1:0];
            y_start_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            x_end_reg   <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            y_end_reg   <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .x_start       (x_start_reg),
        .y_start       (y_start_reg),
        .x_end         (x_end_reg),
        .y_end         (y_end_reg),
        .y_major       (ld_y_major),
        .major_start   (ld_major_start),
        .major_stop    (ld_major_stop),
        .minor_start   (ld_minor_start),
        .minor_dir_neg (ld_minor_dir_neg),
        .delta_major   (ld_delta_major),
        .delta_minor   (ld_delta_minor),
        .decision      (ld_decision),
        .line_busy     (ld_busy)
    );

    lr_core #(.COORD_BITS(COORD_BITS)) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .req_type         (in_type_reg),
        .ld_y_major       (ld_y_major),
        .ld_major_start   (ld_major_start),
        .ld_major_stop    (ld_major_stop),
        .ld_minor_start   (ld_minor_start),
        .ld_minor_dir_neg (ld_minor_dir_neg),
        .ld_delta_major   (ld_delta_major),
        .ld_delta_minor   (ld_delta_minor),
        .ld_decision      (ld_decision),
        .ld_busy          (ld_busy),
        .pixel_valid      (pixel_valid),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .last_pixel       (last_pixel),
        .line_empty       (line_empty)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[COORD_BITS-1:0]            = pixel_x;
        m_tdata[2*COORD_BITS-1:COORD_BITS] = pixel_y;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {line_empty, pixel_valid};
    assign m_tlast  = last_pixel;

endmodule : line_rasterizer_top

>>> rtl/lr_setup.sv
// Line set-up: picks the major axis, orders the endpoints and derives the initial Bresenham terms.
module lr_setup import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DEC_BITS  = COORD_BITS + 4
)
(
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         y_major,
    output logic signed [COORD_BITS-1:0] major_start,
    output logic signed [COORD_BITS-1:0] major_stop,
    output logic signed [COORD_BITS-1:0] minor_start,
    output logic                         minor_dir_neg,
    output logic        [COORD_BITS:0]   delta_major,
    output logic        [COORD_BITS:0]   delta_minor,
    output logic signed [DEC_BITS-1:0]   decision,
    output logic                         line_busy
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   adx;
    logic        [COORD_BITS:0]   ady;
    logic                         rising;
    logic signed [COORD_BITS-1:0] minor_stop;
    logic signed [COORD_BITS:0]   dmin;
    logic signed [COORD_BITS:0]   dmaj;

    always_comb
    begin
        dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
        ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

        // ties and the zero-length line go to y
        y_major = !(ady < adx);
        rising  = y_major ? (dy > 0) : (dx > 0);

        if (y_major)
        begin
            major_start = rising ? y_start : y_end;
            major_stop  = rising ? y_end   : y_start;
            minor_start = rising ? x_start : x_end;
            minor_stop  = rising ? x_end   : x_start;
        end
        else
        begin
            major_start = rising ? x_start : x_end;
            major_stop  = rising ? x_end   : x_start;
            minor_start = rising ? y_start : y_end;
            minor_stop  = rising ? y_end   : y_start;
        end

        dmin = {minor_stop[COORD_BITS-1], minor_stop}
             - {minor_start[COORD_BITS-1], minor_start};
        dmaj = {major_stop[COORD_BITS-1], major_stop}
             - {major_start[COORD_BITS-1], major_start};

        minor_dir_neg = dmin[COORD_BITS];
        delta_minor   = minor_dir_neg ? (COORD_BITS+1)'(-dmin) : dmin;
        delta_major   = dmaj;

        // 2*dminor - dmajor
        decision  = $signed({2'b00, delta_minor, 1'b0}) - $signed({3'b000, delta_major});
        line_busy = major_start < major_stop;
    end

endmodule : lr_setup

>>> rtl/lr_core.sv
// Line state and per-item step: loads a line or emits one pixel into the result register.
module lr_core import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DEC_BITS  = COORD_BITS + 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         req_type,
    input  logic                         ld_y_major,
    input  logic signed [COORD_BITS-1:0] ld_major_start,
    input  logic signed [COORD_BITS-1:0] ld_major_stop,
    input  logic signed [COORD_BITS-1:0] ld_minor_start,
    input  logic                         ld_minor_dir_neg,
    input  logic        [COORD_BITS:0]   ld_delta_major,
    input  logic        [COORD_BITS:0]   ld_delta_minor,
    input  logic signed [DEC_BITS-1:0]   ld_decision,
    input  logic                         ld_busy,
    output logic                         pixel_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last_pixel,
    output logic                         line_empty
);

    logic                         busy_reg;
    logic                         y_major_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] major_stop_reg;
    logic signed [COORD_BITS-1:0] minor_pos_reg;
    logic                         minor_dir_neg_reg;
    logic        [COORD_BITS:0]   delta_major_reg;
    logic        [COORD_BITS:0]   delta_minor_reg;
    logic signed [DEC_BITS-1:0]   decision_reg;

    logic                         pixel_valid_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic                         last_pixel_reg;
    logic                         line_empty_reg;

    logic signed [COORD_BITS:0]   major_inc;
    logic                         is_last;
    logic signed [COORD_BITS-1:0] minor_next;
    logic signed [DEC_BITS-1:0]   dec_moved;
    logic signed [DEC_BITS-1:0]   decision_next;

    always_comb
    begin
        major_inc  = {major_pos_reg[COORD_BITS-1], major_pos_reg} + (COORD_BITS+1)'(1);
        is_last    = major_inc >= $signed({major_stop_reg[COORD_BITS-1], major_stop_reg});
        minor_next = minor_dir_neg_reg ? minor_pos_reg - COORD_BITS'(1)
                                       : minor_pos_reg + COORD_BITS'(1);
        // step the minor axis when the decision term is positive
        dec_moved  = (decision_reg > 0)
                   ? decision_reg - $signed({2'b00, delta_major_reg, 1'b0})
                   : decision_reg;
        decision_next = dec_moved + $signed({2'b00, delta_minor_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            y_major_reg       <= 1'b0;
            major_pos_reg     <= '0;
            major_stop_reg    <= '0;
            minor_pos_reg     <= '0;
            minor_dir_neg_reg <= 1'b0;
            delta_major_reg   <= '0;
            delta_minor_reg   <= '0;
            decision_reg      <= '0;
            pixel_valid_reg   <= 1'b0;
            pixel_x_reg       <= '0;
            pixel_y_reg       <= '0;
            last_pixel_reg    <= 1'b0;
            line_empty_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (req_type == REQ_LOAD)
            begin
                busy_reg          <= ld_busy;
                y_major_reg       <= ld_y_major;
                major_pos_reg     <= ld_major_start;
                major_stop_reg    <= ld_major_stop;
                minor_pos_reg     <= ld_minor_start;
                minor_dir_neg_reg <= ld_minor_dir_neg;
                delta_major_reg   <= ld_delta_major;
                delta_minor_reg   <= ld_delta_minor;
                decision_reg      <= ld_decision;
                pixel_valid_reg   <= 1'b0;
                pixel_x_reg       <= '0;
                pixel_y_reg       <= '0;
                last_pixel_reg    <= 1'b0;
                line_empty_reg    <= !ld_busy;
            end
            else if (busy_reg)
            begin
                pixel_valid_reg <= 1'b1;
                pixel_x_reg     <= y_major_reg ? minor_pos_reg : major_pos_reg;
                pixel_y_reg     <= y_major_reg ? major_pos_reg : minor_pos_reg;
                last_pixel_reg  <= is_last;
                line_empty_reg  <= 1'b0;
                if (decision_reg > 0)
                begin
                    minor_pos_reg <= minor_next;
                end
                decision_reg  <= decision_next;
                major_pos_reg <= major_inc[COORD_BITS-1:0];
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                pixel_valid_reg <= 1'b0;
                pixel_x_reg     <= '0;
                pixel_y_reg     <= '0;
                last_pixel_reg  <= 1'b0;
                line_empty_reg  <= 1'b0;
            end
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign last_pixel  = last_pixel_reg;
    assign line_empty  = line_empty_reg;

endmodule : lr_core

>>> rtl/lr_checker.sv
// Port-level checks for the line rasteriser, bound to the top level.
module lr_checker import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser,
    input logic             m_tlast
);

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a word never carries a pixel and an empty-line answer together
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pixel_valid and line_empty both set");

    // the last-pixel mark only rides on a pixel
    a_last_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last_pixel without pixel_valid");

    // words without a pixel carry zero coordinates
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("non-zero coordinates on a word without a pixel");

endmodule : lr_checker

bind line_rasterizer_top lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

>>> bench/line_rasterizer_top_test.sv
// Self-checking testbench for the Bresenham line rasteriser: queued stimulus, predictor, monitor.
`timescale 1ns / 100ps

module line_rasterizer_top_test;
    import lr_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int IN_W       = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * CB + 7) / 8) * 8;
    localparam int COORD_MAX  = (1 << (CB - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (CB - 1));
    localparam int WORD_COUNT = 2000;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 8;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic                 req;
        logic signed [CB-1:0] xs;
        logic signed [CB-1:0] ys;
        logic signed [CB-1:0] xe;
        logic signed [CB-1:0] ye;
    } line_word_t;

    typedef struct {
        logic                 on;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 fin;
        logic                 none;
    } pixel_word_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;  // x_start, y_start, x_end, y_end
    logic             s_tuser  = 1'b0; // req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // pixel_x, pixel_y
    logic [1:0]       m_tuser;        // pixel_valid, line_empty
    logic             m_tlast;        // last_pixel

    line_rasterizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    line_word_t  pending_words[$];
    pixel_word_t expected_pixels[$];
    line_word_t  bus_word;
    pixel_word_t predicted;
    pixel_word_t wanted;
    pixel_word_t seen;

    // Rasteriser state as the predictor keeps it
    bit line_busy;
    bit along_y;
    int major_at;
    int major_end;
    int minor_at;
    bit minor_down;
    int run_major;
    int run_minor;
    int err_term;

    int cycle_no     = 0;
    int stall_cycles = 0;
    int fail_count   = 0;
    int loads_sent   = 0;
    int empty_lines  = 0;
    int pixels_sent  = 0;
    int last_pixels  = 0;
    int idle_steps   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic signed [CB-1:0] fit_coord(input int v);
        int c;
        begin
            c = v;
            if (c > COORD_MAX)
                c = COORD_MAX;
            if (c < COORD_MIN)
                c = COORD_MIN;
            return c[CB-1:0];
        end
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    // Idle at random outside one long quiet window
    function automatic bit want_gap();
        if (cycle_no >= 1000 && cycle_no < 2200)
            return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    task automatic set_up_line(input int maj0, input int min0, input int maj1, input int min1);
        int dmin;
        begin
            dmin       = min1 - min0;
            minor_down = dmin < 0;
            run_minor  = abs_int(dmin);
            run_major  = maj1 - maj0;
            major_at   = maj0;
            major_end  = maj1;
            minor_at   = min0;
            err_term   = 2 * run_minor - run_major;
            line_busy  = major_at < major_end;
        end
    endtask

    task automatic rasterise_word(input line_word_t w, output pixel_word_t r);
        int  x0, y0, x1, y1, dx, dy;
        bit  fin;
        begin
            r = '{on: 1'b0, px: '0, py: '0, fin: 1'b0, none: 1'b0};
            if (w.req == REQ_LOAD) begin
                x0 = w.xs;
                y0 = w.ys;
                x1 = w.xe;
                y1 = w.ye;
                dx = x1 - x0;
                dy = y1 - y0;
                // ties and the degenerate line go to the y axis
                if (abs_int(dy) < abs_int(dx)) begin
                    along_y = 1'b0;
                    if (dx > 0)
                        set_up_line(x0, y0, x1, y1);
                    else
                        set_up_line(x1, y1, x0, y0);
                end else begin
                    along_y = 1'b1;
                    if (dy > 0)
                        set_up_line(y0, x0, y1, x1);
                    else
                        set_up_line(y1, x1, y0, x0);
                end
                r.none = !line_busy;
            end else if (line_busy) begin
                fin   = (major_at + 1) >= major_end;
                r.on  = 1'b1;
                r.px  = along_y ? minor_at[CB-1:0] : major_at[CB-1:0];
                r.py  = along_y ? major_at[CB-1:0] : minor_at[CB-1:0];
                r.fin = fin;
                if (err_term > 0) begin
                    minor_at = minor_down ? minor_at - 1 : minor_at + 1;
                    err_term = err_term - 2 * run_major;
                end
                err_term = err_term + 2 * run_minor;
                major_at = major_at + 1;
                if (fin)
                    line_busy = 1'b0;
            end
        end
    endtask

    task automatic queue_word(input logic req, input int xs, input int ys,
                              input int xe, input int ye);
        line_word_t w;
        begin
            w.req = req;
            w.xs  = fit_coord(xs);
            w.ys  = fit_coord(ys);
            w.xe  = fit_coord(xe);
            w.ye  = fit_coord(ye);
            pending_words.push_back(w);
        end
    endtask

    // One load followed by step words whose unused fields carry noise
    task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                              input int steps);
        begin
            queue_word(REQ_LOAD, xs, ys, xe, ye);
            repeat (steps)
                queue_word(REQ_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic queue_random_stimulus();
        int xs, ys, xe, ye, span, len, pick, steps, dx, dy;
        begin
            while (pending_words.size() < WORD_COUNT) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    span = (pick < 70) ? 24 : 200;
                    xs   = rand_coord();
                    ys   = rand_coord();
                    dx   = int'($urandom_range(0, 2 * span)) - span;
                    dy   = int'($urandom_range(0, 2 * span)) - span;
                    case ($urandom_range(0, 9))
                        0: dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
                        1: dy = 0;
                        2: dx = 0;
                        default: ;
                    endcase
                    xe    = fit_coord(xs + dx);
                    ye    = fit_coord(ys + dy);
                    len   = abs_int(xe - xs) > abs_int(ye - ys) ?
                            abs_int(xe - xs) : abs_int(ye - ys);
                    steps = len;
                    pick  = $urandom_range(0, 99);
                    if (pick < 15)
                        steps = $urandom_range(0, len);
                    else if (pick < 25)
                        steps = len + $urandom_range(1, 3);
                    queue_line(xs, ys, xe, ye, steps);
                end else if (pick < 92) begin
                    queue_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               $urandom_range(0, 6));
                end else begin
                    repeat ($urandom_range(1, 3))
                        queue_word(REQ_STEP, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord());
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            cycle_no <= cycle_no + 1;
    end

    // Driver: record each accepted word, then present the next one
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                rasterise_word(bus_word, predicted);
                expected_pixels.push_back(predicted);
                if (bus_word.req == REQ_LOAD) begin
                    loads_sent++;
                    if (predicted.none)
                        empty_lines++;
                end else if (predicted.on) begin
                    pixels_sent++;
                    if (predicted.fin)
                        last_pixels++;
                end else begin
                    idle_steps++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && !want_gap()) begin
                    bus_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= bus_word.req;
                    s_tdata  <= IN_W'({bus_word.ye, bus_word.xe, bus_word.ys, bus_word.xs});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= rst_n ? !want_gap() : 1'b0;
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            seen.on   = m_tuser[0];
            seen.none = m_tuser[1];
            seen.px   = m_tdata[CB-1:0];
            seen.py   = m_tdata[2*CB-1:CB];
            seen.fin  = m_tlast;
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result word: valid=%0b x=%0d y=%0d last=%0b empty=%0b",
                             seen.on, seen.px, seen.py, seen.fin, seen.none);
            end else begin
                wanted = expected_pixels.pop_front();
                if (seen.on !== wanted.on || seen.px !== wanted.px ||
                    seen.py !== wanted.py || seen.fin !== wanted.fin ||
                    seen.none !== wanted.none) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $write("mismatch: expected valid=%0b x=%0d y=%0d last=%0b empty=%0b,",
                               wanted.on, wanted.px, wanted.py, wanted.fin, wanted.none);
                        $display(" got valid=%0b x=%0d y=%0d last=%0b empty=%0b",
                                 seen.on, seen.px, seen.py, seen.fin, seen.none);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        // step with no line running
        queue_word(REQ_STEP, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        // zero-length line, then another idle step
        queue_line(0, 0, 0, 0, 1);
        // corner-to-corner diagonals: ties go to y; both are cut short by a reload
        queue_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2);
        queue_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1);
        // full-width horizontal and reversed full-height vertical
        queue_line(COORD_MIN, 0, COORD_MAX, 0, 1);
        queue_line(5, COORD_MAX, 5, COORD_MIN, 1);
        // short lines run to the end, one with an extra step afterwards
        queue_line(0, 0, 3, 1, 4);
        queue_line(3, 1, 0, 0, 3);
        queue_line(-1, -1, -1, -1, 0);
        queue_line(0, 0, -1, -2, 2);
        queue_random_stimulus();

        wait (rst_n);
        while (pending_words.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        fail_count += expected_pixels.size();

        $display("lines loaded: %0d (%0d with no pixels), pixels drawn: %0d, line ends: %0d",
                 loads_sent, empty_lines, pixels_sent, last_pixels);
        $display("steps with no line running: %0d, mismatches: %0d",
                 idle_steps, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
